// ===== rtl/bsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants for the source lexer: payload structs, token
// kinds and the keyword table.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int unsigned NUM_KEYWORDS = 21;
    localparam int unsigned MAX_RESULTS  = 4;
    localparam longint unsigned COLUMN_LIMIT_DEFAULT = 64'd65535;

    // Token kinds.
    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_INT     = 6'd1;
    localparam logic [5:0] K_REAL    = 6'd2;
    localparam logic [5:0] K_STR     = 6'd3;
    localparam logic [5:0] K_KW0     = 6'd4;
    localparam logic [5:0] K_EQUAL   = 6'd25;
    localparam logic [5:0] K_ASSIGN  = 6'd26;
    localparam logic [5:0] K_ADD     = 6'd27;
    localparam logic [5:0] K_SUB     = 6'd28;
    localparam logic [5:0] K_MUL     = 6'd29;
    localparam logic [5:0] K_DIV     = 6'd30;
    localparam logic [5:0] K_NE      = 6'd31;
    localparam logic [5:0] K_LE      = 6'd32;
    localparam logic [5:0] K_LT      = 6'd33;
    localparam logic [5:0] K_GE      = 6'd34;
    localparam logic [5:0] K_GT      = 6'd35;
    localparam logic [5:0] K_NOT     = 6'd36;
    localparam logic [5:0] K_OPEN    = 6'd37;
    localparam logic [5:0] K_CLOSE   = 6'd38;
    localparam logic [5:0] K_COLON   = 6'd39;
    localparam logic [5:0] K_COMMA   = 6'd40;
    localparam logic [5:0] K_NEWLINE = 6'd41;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic        is_text;
        logic [7:0]  text_byte;
        logic [5:0]  kind;
        logic [31:0] line;
        logic [15:0] column;
        logic        last;
    } out_item_t;

    // Keyword text, nine characters each, first character in the top byte.
    function automatic logic [71:0] kw_text(input logic [4:0] k);
        logic [71:0] t;
        t = '0;
        case (k)
            5'd0:  t = {"false", 32'h0};
            5'd1:  t = {"true", 40'h0};
            5'd2:  t = {"if", 56'h0};
            5'd3:  t = {"then", 40'h0};
            5'd4:  t = {"case", 40'h0};
            5'd5:  t = {"of", 56'h0};
            5'd6:  t = {"when", 40'h0};
            5'd7:  t = "otherwise";
            5'd8:  t = {"for", 48'h0};
            5'd9:  t = {"to", 56'h0};
            5'd10: t = {"next", 40'h0};
            5'd11: t = {"repeat", 24'h0};
            5'd12: t = {"until", 32'h0};
            5'd13: t = {"while", 32'h0};
            5'd14: t = {"do", 56'h0};
            5'd15: t = {"end", 48'h0};
            5'd16: t = {"dim", 48'h0};
            5'd17: t = {"data", 40'h0};
            5'd18: t = {"def", 48'h0};
            5'd19: t = {"sub", 48'h0};
            5'd20: t = {"call", 40'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] k);
        logic [3:0] n;
        case (k)
            5'd0, 5'd12, 5'd13:                          n = 4'd5;
            5'd1, 5'd3, 5'd4, 5'd6, 5'd10, 5'd17, 5'd20: n = 4'd4;
            5'd2, 5'd5, 5'd9, 5'd14:                     n = 4'd2;
            5'd7:                                        n = 4'd9;
            5'd11:                                       n = 4'd6;
            default:                                     n = 4'd3;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/basic_source_lexer_top.sv =====
// ----------------------------------------------------------------------------
// basic_source_lexer_top
// Streaming lexer: characters in, text beats and token records out.
// ----------------------------------------------------------------------------
// Usage: source characters arrive as beats on in_valid/in_ready/in_data, one
// character (or an empty line marker) per beat. Each beat causes zero to three
// result beats on out_valid/out_ready/out_data; the last result of a beat
// carries last. Text beats of words, numbers and strings come as the
// characters arrive; a token record follows when the token closes.
// An accepted character is decoded into a result register of up to four
// entries, which then drains one beat per cycle while out_ready is high; the
// first result is valid in the cycle after the accept. A new character is
// accepted as the last result of the last beat leaves, so plain text runs
// at one character per cycle while out_ready is high; token records add beats.
// Beats that cause no result pass at one per cycle.
// Reset clears the scanner to idle with line number 0; a write on cfg_we
// loads the first line number into the line counter. A stall on out_ready holds
// the result register and, once it is still full, stops input.
// ----------------------------------------------------------------------------
module basic_source_lexer_top #(
    parameter longint unsigned COLUMN_LIMIT = bsl_pkg::COLUMN_LIMIT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsl_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bsl_pkg::out_item_t out_data
);

    localparam logic [15:0] COL_CAP =
        (COLUMN_LIMIT < 64'd65535) ? 16'(COLUMN_LIMIT) : 16'hFFFF;
    localparam int unsigned NKW = bsl_pkg::NUM_KEYWORDS;
    localparam int unsigned NRES = bsl_pkg::MAX_RESULTS;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_NUMPT, M_STR, M_MINUS, M_EQ, M_LT, M_GT
    } mode_t;

    // Scanner state.
    mode_t            mode_reg, mode_next;
    logic [15:0]      tcol_reg, tcol_next;
    logic [15:0]      ncol_reg, ncol_next;
    logic [31:0]      line_reg, line_next;
    logic [NKW-1:0]   cand_reg, cand_next;
    logic [3:0]       wlen_reg, wlen_next;
    logic             pt_reg, pt_next;

    // Result register: entries plus a count and read pointer.
    bsl_pkg::out_item_t res_reg [NRES];
    bsl_pkg::out_item_t res_next [NRES];
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       rd_reg;

    logic             take;
    logic             drain_last;

    assign out_valid  = (cnt_reg != 3'd0);
    assign out_data   = res_reg[rd_reg];
    assign drain_last = (cnt_reg == 3'd1) && out_ready;
    assign in_ready   = (cnt_reg == 3'd0) || drain_last;
    assign take       = in_valid && in_ready;

    // Per-character decode into up to three results.
    always_comb
    begin
        logic [7:0]  c;
        logic        let_c, dig_c, cont, closing, starting;
        logic [15:0] col;
        logic [2:0]  n;
        logic [5:0]  close_kind;
        logic        close_emit;
        logic [NKW-1:0] cw;
        logic [3:0]  wl;
        logic [3:0]  p;
        logic [71:0] t;
        logic [15:0] tc;
        logic [7:0]  tb [NRES];
        logic        tx [NRES];
        logic [5:0]  tk [NRES];
        logic [15:0] cl [NRES];
        logic [31:0] ln [NRES];

        c     = in_data.char_byte;
        let_c = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        dig_c = (c >= "0" && c <= "9");
        col   = ncol_reg;

        mode_next = mode_reg;
        tcol_next = tcol_reg;
        ncol_next = ncol_reg;
        line_next = line_reg;
        cand_next = cand_reg;
        wlen_next = wlen_reg;
        pt_next   = pt_reg;
        n         = 3'd0;
        cont      = 1'b0;
        starting  = 1'b0;
        closing   = 1'b0;
        close_kind = bsl_pkg::K_IDENT;
        close_emit = 1'b0;
        cw = '0;
        wl = '0;
        p  = '0;
        t  = '0;
        tc = tcol_reg;
        for (int i = 0; i < NRES; i++)
        begin
            tb[i] = '0;
            tx[i] = 1'b0;
            tk[i] = '0;
            cl[i] = tcol_reg;
            ln[i] = line_reg;
        end

        if (in_data.has_char)
        begin
            if (ncol_reg < COL_CAP)
                ncol_next = ncol_reg + 16'd1;
            // Continue the open token where the character extends it.
            case (mode_reg)
                M_WORD:
                    if (let_c || dig_c)
                    begin
                        cont = 1'b1;
                        tx[0] = 1'b1; tb[0] = c; n = 3'd1;
                    end
                M_NUM:
                    if (dig_c)
                    begin
                        cont = 1'b1; tx[0] = 1'b1; tb[0] = c; n = 3'd1;
                    end
                    else if (c == "." && !pt_reg)
                    begin
                        cont = 1'b1; mode_next = M_NUMPT;
                    end
                M_NUMPT, M_MINUS:
                    if (dig_c)
                    begin
                        cont = 1'b1;
                        tx[0] = 1'b1; tb[0] = (mode_reg == M_NUMPT) ? "." : "-";
                        tx[1] = 1'b1; tb[1] = c; n = 3'd2;
                        pt_next = (mode_reg == M_NUMPT);
                        mode_next = M_NUM;
                    end
                M_STR:
                begin
                    cont = 1'b1;
                    if (c == "\"")
                    begin
                        tk[0] = bsl_pkg::K_STR; mode_next = M_IDLE;
                    end
                    else
                    begin
                        tx[0] = 1'b1; tb[0] = c;
                    end
                    n = 3'd1;
                end
                M_EQ:
                    if (c == "=")
                    begin
                        cont = 1'b1; tk[0] = bsl_pkg::K_EQUAL; n = 3'd1;
                        mode_next = M_IDLE;
                    end
                M_LT:
                    if (c == ">" || c == "=")
                    begin
                        cont = 1'b1; n = 3'd1; mode_next = M_IDLE;
                        tk[0] = (c == ">") ? bsl_pkg::K_NE : bsl_pkg::K_LE;
                    end
                M_GT:
                    if (c == "=")
                    begin
                        cont = 1'b1; tk[0] = bsl_pkg::K_GE; n = 3'd1;
                        mode_next = M_IDLE;
                    end
                default: ;
            endcase
            closing  = !cont;
            starting = !cont;
        end
        // A line end also closes what is open after this character.
        if (in_data.end_of_line)
            closing = 1'b1;

        // Word candidate update for a continued word.
        if (cont && mode_reg == M_WORD)
        begin
            p = (wlen_reg < 4'd9) ? wlen_reg : 4'd9;
            for (int k = 0; k < NKW; k++)
            begin
                t = bsl_pkg::kw_text(5'(k));
                cand_next[k] = cand_reg[k] && (wlen_reg < bsl_pkg::kw_len(5'(k)))
                    && (p < 4'd9) && (t[71 - 8*p -: 8] == c);
            end
            wlen_next = (wlen_reg < 4'd15) ? wlen_reg + 4'd1 : wlen_reg;
        end

        // Close record of the token open before this character's start.
        if (closing)
        begin
            // When a line end closes a token continued by this character,
            // the mode to close is the updated one.
            mode_t cm;
            cm = (in_data.has_char && cont) ? mode_next : mode_reg;
            if (in_data.has_char && !cont)
                cm = mode_reg;
            cw = (in_data.has_char && cont) ? cand_next : cand_reg;
            wl = (in_data.has_char && cont) ? wlen_next : wlen_reg;
            close_emit = 1'b1;
            case (cm)
                M_WORD:
                begin
                    close_kind = bsl_pkg::K_IDENT;
                    for (int k = 0; k < NKW; k++)
                        if (cw[k] && bsl_pkg::kw_len(5'(k)) == wl)
                            close_kind = bsl_pkg::K_KW0 + 6'(k);
                end
                M_NUM, M_NUMPT:
                    close_kind = ((in_data.has_char && cont) ? pt_next : pt_reg)
                        ? bsl_pkg::K_REAL : bsl_pkg::K_INT;
                M_STR:   close_kind = bsl_pkg::K_STR;
                M_MINUS: close_kind = bsl_pkg::K_SUB;
                M_EQ:    close_kind = bsl_pkg::K_ASSIGN;
                M_LT:    close_kind = bsl_pkg::K_LT;
                M_GT:    close_kind = bsl_pkg::K_GT;
                default: close_emit = 1'b0;
            endcase
        end

        if (starting)
        begin
            // Close of the old token, then the new token's start.
            if (close_emit)
            begin
                tk[0] = close_kind; n = 3'd1;
            end
            tc = col;
            mode_next = M_IDLE;
            if (let_c)
            begin
                mode_next = M_WORD;
                for (int k = 0; k < NKW; k++)
                begin
                    t = bsl_pkg::kw_text(5'(k));
                    cand_next[k] = (t[71:64] == c);
                end
                wlen_next = 4'd1;
                tx[n[1:0]] = 1'b1; tb[n[1:0]] = c; cl[n[1:0]] = tc; n = n + 3'd1;
            end
            else if (dig_c)
            begin
                mode_next = M_NUM; pt_next = 1'b0;
                tx[n[1:0]] = 1'b1; tb[n[1:0]] = c; cl[n[1:0]] = tc; n = n + 3'd1;
            end
            else
            begin
                case (c)
                    "-":  mode_next = M_MINUS;
                    "\"": mode_next = M_STR;
                    "=":  mode_next = M_EQ;
                    "<":  mode_next = M_LT;
                    ">":  mode_next = M_GT;
                    "+", "*", "/", "!", "(", ")", ":", ",", 8'd10:
                    begin
                        case (c)
                            "+":  tk[n[1:0]] = bsl_pkg::K_ADD;
                            "*":  tk[n[1:0]] = bsl_pkg::K_MUL;
                            "/":  tk[n[1:0]] = bsl_pkg::K_DIV;
                            "!":  tk[n[1:0]] = bsl_pkg::K_NOT;
                            "(":  tk[n[1:0]] = bsl_pkg::K_OPEN;
                            ")":  tk[n[1:0]] = bsl_pkg::K_CLOSE;
                            ":":  tk[n[1:0]] = bsl_pkg::K_COLON;
                            ",":  tk[n[1:0]] = bsl_pkg::K_COMMA;
                            default: tk[n[1:0]] = bsl_pkg::K_NEWLINE;
                        endcase
                        cl[n[1:0]] = tc; n = n + 3'd1;
                    end
                    default: ;
                endcase
            end
            tcol_next = tc;
            // A line end then closes the freshly started token.
            if (in_data.end_of_line)
            begin
                close_emit = 1'b1;
                case (mode_next)
                    M_WORD:
                    begin
                        close_kind = bsl_pkg::K_IDENT;
                        for (int k = 0; k < NKW; k++)
                            if (cand_next[k] && bsl_pkg::kw_len(5'(k)) == 4'd1)
                                close_kind = bsl_pkg::K_KW0 + 6'(k);
                    end
                    M_NUM:   close_kind = bsl_pkg::K_INT;
                    M_STR:   close_kind = bsl_pkg::K_STR;
                    M_MINUS: close_kind = bsl_pkg::K_SUB;
                    M_EQ:    close_kind = bsl_pkg::K_ASSIGN;
                    M_LT:    close_kind = bsl_pkg::K_LT;
                    M_GT:    close_kind = bsl_pkg::K_GT;
                    default: close_emit = 1'b0;
                endcase
                if (close_emit)
                begin
                    tk[n[1:0]] = close_kind; cl[n[1:0]] = tc; n = n + 3'd1;
                end
            end
        end
        else if (in_data.end_of_line && close_emit)
        begin
            tk[n[1:0]] = close_kind; n = n + 3'd1;
        end

        if (in_data.end_of_line)
        begin
            mode_next = M_IDLE;
            ncol_next = '0;
            line_next = line_reg + 32'd1;
        end

        for (int i = 0; i < NRES; i++)
        begin
            res_next[i].is_text   = tx[i];
            res_next[i].text_byte = tx[i] ? tb[i] : 8'd0;
            res_next[i].kind      = tx[i] ? 6'd0 : tk[i];
            res_next[i].line      = ln[i];
            res_next[i].column    = cl[i];
            res_next[i].last      = (3'(i) + 3'd1 == n);
        end
        cnt_next = n;
    end

    // State, result register and drain pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            tcol_reg <= '0;
            ncol_reg <= '0;
            line_reg <= '0;
            cand_reg <= '1;
            wlen_reg <= '0;
            pt_reg   <= 1'b0;
            cnt_reg  <= '0;
            rd_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                line_reg <= cfg_wdata;
            if (take)
            begin
                mode_reg <= mode_next;
                tcol_reg <= tcol_next;
                ncol_reg <= ncol_next;
                if (!cfg_we)
                    line_reg <= line_next;
                cand_reg <= cand_next;
                wlen_reg <= wlen_next;
                pt_reg   <= pt_next;
                cnt_reg  <= cnt_next;
                rd_reg   <= '0;
                res_reg  <= res_next;
            end
            else if (out_valid && out_ready)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                rd_reg  <= rd_reg + 2'd1;
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Source lexer testbench
// Streams directed and random source lines into the lexer and checks every
// text beat and token record against a cycle-free prediction of the scanner.
// It also covers line-number settings, wrap of the line counter and
// back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_POINT, SCAN_STR,
        SCAN_MINUS, SCAN_EQ, SCAN_LT, SCAN_GT
    } scan_t;

    // Scoreboard: predicts the results of each accepted beat and checks
    // the result beats in order.
    class lexer_scoreboard;
        bsl_pkg::out_item_t expected_q[$];
        bsl_pkg::out_item_t step_q[$];
        int          errors;
        int          beats_in;
        int          beats_out;
        logic [31:0] line_no;
        logic [15:0] tok_col;
        logic [15:0] nxt_col;
        scan_t       mode;
        logic [20:0] cand;
        int          wlen;
        bit          got_point;
        string       words[21] = '{"false", "true", "if", "then", "case", "of", "when",
            "otherwise", "for", "to", "next", "repeat", "until", "while", "do", "end",
            "dim", "data", "def", "sub", "call"};

        function void clear_state();
            line_no = '0;
            tok_col = '0;
            nxt_col = '0;
            mode = SCAN_IDLE;
            cand = '1;
            wlen = 0;
            got_point = 1'b0;
        endfunction

        function void set_first_line(logic [31:0] v);
            line_no = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void emit(bit txt, logic [7:0] b, logic [5:0] kind);
            bsl_pkg::out_item_t r;
            if (step_q.size() >= bsl_pkg::MAX_RESULTS)
                return;
            r.is_text = txt;
            r.text_byte = b;
            r.kind = kind;
            r.line = line_no;
            r.column = tok_col;
            r.last = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        // Narrow the keyword candidates by the character at this position.
        function void word_char(logic [7:0] c);
            for (int k = 0; k < 21; k++)
            begin
                if (!(wlen < words[k].len() && words[k][wlen] == c))
                    cand[k] = 1'b0;
            end
            if (wlen < 15)
                wlen++;
            emit(1'b1, c, bsl_pkg::K_IDENT);
        endfunction

        function void close_token();
            logic [5:0] kind;
            case (mode) inside
                SCAN_WORD:
                begin
                    kind = bsl_pkg::K_IDENT;
                    for (int k = 0; k < 21; k++)
                    begin
                        if (cand[k] && words[k].len() == wlen)
                            kind = bsl_pkg::K_KW0 + 6'(k);
                    end
                    emit(1'b0, 8'h00, kind);
                end
                SCAN_NUM, SCAN_POINT:
                    emit(1'b0, 8'h00, got_point ? bsl_pkg::K_REAL : bsl_pkg::K_INT);
                SCAN_STR:   emit(1'b0, 8'h00, bsl_pkg::K_STR);
                SCAN_MINUS: emit(1'b0, 8'h00, bsl_pkg::K_SUB);
                SCAN_EQ:    emit(1'b0, 8'h00, bsl_pkg::K_ASSIGN);
                SCAN_LT:    emit(1'b0, 8'h00, bsl_pkg::K_LT);
                SCAN_GT:    emit(1'b0, 8'h00, bsl_pkg::K_GT);
                default: ;
            endcase
            mode = SCAN_IDLE;
        endfunction

        function void start_token(logic [7:0] c, logic [15:0] col);
            tok_col = col;
            mode = SCAN_IDLE;
            if (is_letter(c))
            begin
                mode = SCAN_WORD;
                cand = '1;
                wlen = 0;
                word_char(c);
            end
            else if (is_digit(c))
            begin
                mode = SCAN_NUM;
                got_point = 1'b0;
                emit(1'b1, c, bsl_pkg::K_IDENT);
            end
            else
            begin
                case (c)
                    "-":   mode = SCAN_MINUS;
                    "\"":  mode = SCAN_STR;
                    "=":   mode = SCAN_EQ;
                    "<":   mode = SCAN_LT;
                    ">":   mode = SCAN_GT;
                    "+":   emit(1'b0, 8'h00, bsl_pkg::K_ADD);
                    "*":   emit(1'b0, 8'h00, bsl_pkg::K_MUL);
                    "/":   emit(1'b0, 8'h00, bsl_pkg::K_DIV);
                    "!":   emit(1'b0, 8'h00, bsl_pkg::K_NOT);
                    "(":   emit(1'b0, 8'h00, bsl_pkg::K_OPEN);
                    ")":   emit(1'b0, 8'h00, bsl_pkg::K_CLOSE);
                    ":":   emit(1'b0, 8'h00, bsl_pkg::K_COLON);
                    ",":   emit(1'b0, 8'h00, bsl_pkg::K_COMMA);
                    8'h0A: emit(1'b0, 8'h00, bsl_pkg::K_NEWLINE);
                    default: ;
                endcase
            end
        endfunction

        // Returns 1 when the character extends the open token.
        function bit extend_token(logic [7:0] c);
            case (mode)
                SCAN_WORD:
                    if (is_letter(c) || is_digit(c))
                    begin
                        word_char(c);
                        return 1'b1;
                    end
                SCAN_NUM:
                    if (is_digit(c))
                    begin
                        emit(1'b1, c, bsl_pkg::K_IDENT);
                        return 1'b1;
                    end
                    else if (c == "." && !got_point)
                    begin
                        mode = SCAN_POINT;
                        return 1'b1;
                    end
                SCAN_POINT:
                    if (is_digit(c))
                    begin
                        emit(1'b1, ".", bsl_pkg::K_IDENT);
                        emit(1'b1, c, bsl_pkg::K_IDENT);
                        got_point = 1'b1;
                        mode = SCAN_NUM;
                        return 1'b1;
                    end
                SCAN_STR:
                begin
                    if (c == "\"")
                    begin
                        emit(1'b0, 8'h00, bsl_pkg::K_STR);
                        mode = SCAN_IDLE;
                    end
                    else
                        emit(1'b1, c, bsl_pkg::K_IDENT);
                    return 1'b1;
                end
                SCAN_MINUS:
                    if (is_digit(c))
                    begin
                        emit(1'b1, "-", bsl_pkg::K_IDENT);
                        emit(1'b1, c, bsl_pkg::K_IDENT);
                        got_point = 1'b0;
                        mode = SCAN_NUM;
                        return 1'b1;
                    end
                SCAN_EQ:
                    if (c == "=")
                    begin
                        emit(1'b0, 8'h00, bsl_pkg::K_EQUAL);
                        mode = SCAN_IDLE;
                        return 1'b1;
                    end
                SCAN_LT:
                    if (c == ">" || c == "=")
                    begin
                        emit(1'b0, 8'h00, (c == ">") ? bsl_pkg::K_NE : bsl_pkg::K_LE);
                        mode = SCAN_IDLE;
                        return 1'b1;
                    end
                SCAN_GT:
                    if (c == "=")
                    begin
                        emit(1'b0, 8'h00, bsl_pkg::K_GE);
                        mode = SCAN_IDLE;
                        return 1'b1;
                    end
                default: ;
            endcase
            return 1'b0;
        endfunction

        // Work out the results of one accepted input beat.
        function void note_input(bsl_pkg::in_item_t it);
            logic [15:0] col;
            step_q.delete();
            beats_in++;
            if (it.has_char)
            begin
                col = nxt_col;
                if (nxt_col != 16'hFFFF)
                    nxt_col++;
                if (!extend_token(it.char_byte))
                begin
                    close_token();
                    start_token(it.char_byte, col);
                end
            end
            if (it.end_of_line)
            begin
                close_token();
                nxt_col = '0;
                line_no++;
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        function void compare_field(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(bsl_pkg::out_item_t got);
            bsl_pkg::out_item_t e;
            beats_out++;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: %0h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("is_text", e.is_text, got.is_text);
            compare_field("text_byte", e.text_byte, got.text_byte);
            compare_field("kind", e.kind, got.kind);
            compare_field("line", e.line, got.line);
            compare_field("column", e.column, got.column);
            compare_field("last", e.last, got.last);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [31:0] cfg_wdata;
    logic      in_valid;
    logic      in_ready;
    bsl_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    bsl_pkg::out_item_t out_data;

    lexer_scoreboard sb = new;
    int  hold_reqs;
    int  idle_cycles;
    int  settings_used;
    int  send_burst;
    logic [7:0] line_q[$];

    basic_source_lexer_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check every result beat at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches and one long hold-off.
    initial
    begin
        int gap;
        int quiet;
        int holds_seen;
        quiet = 0;
        holds_seen = 0;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (quiet > 0)
            begin
                quiet--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 30) == 0)
                    quiet = 40;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // Offer one input beat and wait until it is taken.
    task automatic send_beat(logic [7:0] c, bit has, bit eol, bit no_gap);
        bsl_pkg::in_item_t it;
        int gap;
        it.char_byte = c;
        it.has_char = has;
        it.end_of_line = eol;
        if (no_gap || send_burst > 0)
        begin
            gap = 0;
            if (send_burst > 0)
                send_burst--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 30) == 0)
                send_burst = 30;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    // Send the collected line; the last character carries the line end.
    task automatic send_line();
        if (line_q.size() == 0)
            send_beat(8'h00, 1'b0, 1'b1, 1'b0);
        foreach (line_q[i])
            send_beat(line_q[i], 1'b1, i == line_q.size() - 1, 1'b0);
        line_q.delete();
    endtask

    function automatic void append_char(logic [7:0] c);
        line_q.insert(line_q.size(), c);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endfunction

    // Stop offering and wait until every expected result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_first_line(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_first_line(v);
        settings_used++;
    endtask

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range("a", "z"));
            1: return 8'($urandom_range("A", "Z"));
            default: return "_";
        endcase
    endfunction

    // Append one random token, mostly well formed, sometimes broken or noise.
    function automatic void add_token();
        string ops[18] = '{"==", "=", "+", "-", "*", "/", "<>", "<=", "<", ">=", ">",
            "!", "(", ")", ":", ",", "\n", "."};
        int n;
        string w;
        case ($urandom_range(0, 9)) inside
            0, 1:
            begin
                w = sb.words[$urandom_range(0, 20)];
                case ($urandom_range(0, 4))
                    0: w = {w, "x"};
                    1: w = w.substr(0, w.len() - 2 < 0 ? 0 : w.len() - 2);
                    default: ;
                endcase
                add_text(w);
            end
            2:
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
                append_char(rand_letter());
                for (int i = 1; i < n; i++)
                    append_char($urandom_range(0, 3) == 0 ?
                        8'($urandom_range("0", "9")) : rand_letter());
            end
            3, 4:
            begin
                if ($urandom_range(0, 2) == 0)
                    append_char("-");
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    append_char(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 1) == 0)
                begin
                    append_char(".");
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++)
                        append_char(8'($urandom_range("0", "9")));
                end
            end
            5:
            begin
                append_char("\"");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    append_char($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255)) :
                        8'($urandom_range("a", "z")));
                if ($urandom_range(0, 4) != 0)
                    append_char("\"");
            end
            6, 7: add_text(ops[$urandom_range(0, 17)]);
            8: append_char(8'($urandom_range(0, 255)));
            default: append_char(" ");
        endcase
        if ($urandom_range(0, 2) == 0)
            append_char(" ");
    endfunction

    // Random lines until about the given number of beats were sent.
    task automatic random_lines(int beats, bit with_pressure);
        int start;
        int ntok;
        bit held;
        bit drained;
        start = sb.beats_in;
        held = 1'b0;
        drained = 1'b0;
        while (sb.beats_in - start < beats)
        begin
            if ($urandom_range(0, 12) != 0)
            begin
                ntok = $urandom_range(1, 6);
                repeat (ntok) add_token();
            end
            send_line();
            // Once past a third, the receiver holds off for a long stretch.
            if (with_pressure && !held && sb.beats_in - start > beats / 3)
            begin
                hold_reqs++;
                held = 1'b1;
            end
            // Once past two thirds, the sender waits for a full drain.
            if (with_pressure && !drained && sb.beats_in - start > 2 * beats / 3)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    initial
    begin
        sb.clear_state();
        settings_used = 0;
        send_burst = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: top line number so the counter wraps, then the odd cases.
        write_first_line(32'hFFFF_FFFF);
        add_text("\"\" ==1..-a");
        send_line();
        add_text("x<>-7.5\"s");
        send_line();
        line_q = '{8'hFF, 8'h00, 8'h0A, "<"};
        send_line();
        send_line();
        wait_drained();

        // Random phases at several line-number settings, one with pressure.
        write_first_line(32'h0);
        random_lines(100, 1'b1);
        wait_drained();
        write_first_line($urandom());
        random_lines(60, 1'b0);
        wait_drained();

        write_first_line(32'h7FFF_FFFF);
        add_text("ab+");
        send_line();
        random_lines(60, 1'b0);
        wait_drained();

        $display("Sent %0d input beats and checked %0d result beats across %0d line settings,",
            sb.beats_in, sb.beats_out, settings_used);
        $display("including wrap of the line number, empty lines, a long output hold-off "
            , "and a full drain.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
